>>> design/dts_pkg.sv
`default_nettype none
package dts_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_DELAY  = 2'd1;
  localparam logic [1:0] OP_LOCK   = 2'd2;
  localparam logic [1:0] OP_UNLOCK = 2'd3;

  localparam logic [1:0] TASK_A    = 2'd0;
  localparam logic [1:0] TASK_B    = 2'd1;
  localparam logic [1:0] TASK_IDLE = 2'd2;

  localparam logic [7:0] LOCK_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0] running_now;
    logic       switched;
    logic [7:0] lock_level;
  } out_item_t;

endpackage
`default_nettype wire

>>> design/dts_core.sv
`default_nettype none
module dts_core #(
  parameter int COUNT_WIDTH = dts_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire dts_pkg::in_item_t item,
  output dts_pkg::out_item_t     result
);
  import dts_pkg::*;

  logic [COUNT_WIDTH-1:0] a_cnt_r, a_cnt_nxt;
  logic [COUNT_WIDTH-1:0] b_cnt_r, b_cnt_nxt;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [1:0]             run_r, run_nxt;
  logic [7:0]             lock_r, lock_nxt;
  logic                   resched;
  logic                   sw;

  assign ticks = COUNT_WIDTH'(item.delay_ticks);

  // apply the operation to counters and lock depth
  always_comb begin
    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    lock_nxt  = lock_r;
    resched   = 1'b0;
    unique case (item.operation)
      OP_TICK: begin
        if (a_cnt_r != '0) a_cnt_nxt = a_cnt_r - COUNT_WIDTH'(1);
        if (b_cnt_r != '0) b_cnt_nxt = b_cnt_r - COUNT_WIDTH'(1);
        resched = 1'b1;
      end
      OP_DELAY: begin
        if (run_r == TASK_A) a_cnt_nxt = ticks;
        else if (run_r == TASK_B) b_cnt_nxt = ticks;
        resched = 1'b1;
      end
      OP_LOCK: begin
        if (lock_r != LOCK_MAX) lock_nxt = lock_r + 8'd1;
      end
      OP_UNLOCK: begin
        if (lock_r != 8'd0) begin
          lock_nxt = lock_r - 8'd1;
          resched  = (lock_r == 8'd1);
        end
      end
      default: ;
    endcase
  end

  // pick the next task from the updated counters
  always_comb begin
    run_nxt = run_r;
    sw      = 1'b0;
    if (resched && lock_nxt == 8'd0) begin
      unique case (run_r)
        TASK_A: begin
          if (b_cnt_nxt == '0) begin
            run_nxt = TASK_B;
            sw      = 1'b1;
          end else if (a_cnt_nxt != '0) begin
            run_nxt = TASK_IDLE;
            sw      = 1'b1;
          end
        end
        TASK_B: begin
          if (a_cnt_nxt == '0) begin
            run_nxt = TASK_A;
            sw      = 1'b1;
          end else if (b_cnt_nxt != '0) begin
            run_nxt = TASK_IDLE;
            sw      = 1'b1;
          end
        end
        default: begin
          // idle, and the unused code treated as idle
          if (a_cnt_nxt == '0) begin
            run_nxt = TASK_A;
            sw      = 1'b1;
          end else if (b_cnt_nxt == '0) begin
            run_nxt = TASK_B;
            sw      = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      run_r   <= TASK_A;
      lock_r  <= 8'd0;
    end else if (step) begin
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      run_r   <= run_nxt;
      lock_r  <= lock_nxt;
    end
  end

  assign result.running_now = run_nxt;
  assign result.switched    = sw;
  assign result.lock_level  = lock_nxt;

endmodule
`default_nettype wire

>>> design/two_task_delay_scheduler.sv
`default_nettype none
// channel  direction  payload      handshake
// in_      input      in_item_t    in_valid / in_ready
// out_     output     out_item_t   out_valid / out_ready
//
// one item per cycle sustained while out_ready is high; an accepted input
// reaches result valid through the input register, then the result register
// the scheduler state updates when an item moves from the input register
// into the result register
// a stalled result holds the input register; in_ready stays high while the
// input register is empty or drains in the same cycle
// synchronous active-low reset clears all counters, lock depth and valids
module two_task_delay_scheduler #(
  parameter int COUNT_WIDTH = dts_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dts_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dts_pkg::out_item_t      out_data
);
  import dts_pkg::*;

  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  dts_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire
